@@ src/dtq_pkg.sv @@
// Package for the deadline timer queue: default sizes, command codes and result kinds.
// No dependencies.
package dtq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int TARGET_BITS_DEF = 8;
    localparam int TIME_BITS_DEF   = 32;
    localparam int STAMP_BITS      = 32;
    localparam int OP_BITS         = 3;
    localparam int KIND_BITS       = 2;

    localparam logic [OP_BITS-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_BITS-1:0] OP_SCHEDULE   = 3'd1;
    localparam logic [OP_BITS-1:0] OP_CANCEL_ALL = 3'd2;
    localparam logic [OP_BITS-1:0] OP_CANCEL_ONE = 3'd3;
    localparam logic [OP_BITS-1:0] OP_RESCHEDULE = 3'd4;
    localparam logic [OP_BITS-1:0] OP_NOP        = 3'd7;

    localparam logic [KIND_BITS-1:0] KIND_FIRED = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_FULL  = 2'd2;

endpackage

@@ src/dtq_fifo.sv @@
// Two-entry item queue used between the front and back and on the result side.
// No dependencies.
module dtq_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr <= !r_wr;
            end
            if (rd_en) begin
                r_rd <= !r_rd;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

@@ src/dtq_front.sv @@
// Front end: classifies each request and holds it in a short command queue.
// Depends on dtq_pkg and dtq_fifo.
module dtq_front
    import dtq_pkg::*;
#(
    parameter int TARGET_BITS = TARGET_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_full,
    input  logic [OP_BITS-1:0]     i_op,
    input  logic [TARGET_BITS-1:0] i_target,
    input  logic [TIME_BITS-1:0]   i_deadline,
    input  logic [TIME_BITS-1:0]   i_new_deadline,
    input  logic [TIME_BITS-1:0]   i_now,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic [OP_BITS-1:0]     o_code,
    output logic [TARGET_BITS-1:0] o_target,
    output logic [TIME_BITS-1:0]   o_deadline,
    output logic [TIME_BITS-1:0]   o_new_deadline,
    output logic [TIME_BITS-1:0]   o_now
);

    localparam int W = OP_BITS + TARGET_BITS + 3 * TIME_BITS;

    logic [OP_BITS-1:0] code;
    logic [W-1:0]       q_out;

    always_comb begin
        case (i_op)
            OP_TICK, OP_SCHEDULE, OP_CANCEL_ALL, OP_CANCEL_ONE, OP_RESCHEDULE: code = i_op;
            default: code = OP_NOP;
        endcase
    end

    dtq_fifo #(.WIDTH(W)) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  ({code, i_target, i_deadline, i_new_deadline, i_now}),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (q_out),
        .o_empty (o_empty)
    );

    assign {o_code, o_target, o_deadline, o_new_deadline, o_now} = q_out;

endmodule

@@ src/dtq_back.sv @@
// Back end: timer table in a memory, one slot scanned per cycle, results one at a time.
// Depends on dtq_pkg.
module dtq_back
    import dtq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int TARGET_BITS = TARGET_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_empty,
    output logic                   o_cmd_pop,
    input  logic [OP_BITS-1:0]     i_code,
    input  logic [TARGET_BITS-1:0] i_target,
    input  logic [TIME_BITS-1:0]   i_deadline,
    input  logic [TIME_BITS-1:0]   i_new_deadline,
    input  logic [TIME_BITS-1:0]   i_now,
    input  logic                   i_res_full,
    output logic                   o_res_push,
    output logic [KIND_BITS-1:0]   o_kind,
    output logic [TARGET_BITS-1:0] o_target,
    output logic [TIME_BITS-1:0]   o_deadline,
    output logic                   o_last
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW = TARGET_BITS + TIME_BITS + STAMP_BITS;
    localparam logic [IW:0] LAST_IDX = (IW + 1)'(DEPTH - 1);
    localparam logic [IW:0] DEPTH_N  = (IW + 1)'(DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;
    localparam logic [1:0] ST_PUSH   = 2'd3;

    logic [MW-1:0]          r_mem [DEPTH];
    logic [MW-1:0]          r_rd;
    logic [DEPTH-1:0]       r_valid;
    logic [1:0]             r_state;
    logic [IW:0]            r_idx;
    logic [IW-1:0]          r_cidx;
    logic                   r_cvalid;
    logic [STAMP_BITS-1:0]  r_icount;

    logic [OP_BITS-1:0]     r_code;
    logic [TARGET_BITS-1:0] r_tgt;
    logic [TIME_BITS-1:0]   r_dl;
    logic [TIME_BITS-1:0]   r_ndl;
    logic [TIME_BITS-1:0]   r_now;

    logic                   r_found;
    logic [IW-1:0]          r_best;
    logic [TIME_BITS-1:0]   r_best_dl;
    logic [TARGET_BITS-1:0] r_best_tgt;
    logic [STAMP_BITS-1:0]  r_best_age;
    logic                   r_free_found;
    logic [IW-1:0]          r_free;
    logic [IW:0]            r_count;

    logic [KIND_BITS-1:0]   r_kind;
    logic [TARGET_BITS-1:0] r_otgt;
    logic [TIME_BITS-1:0]   r_odl;
    logic                   r_olast;
    logic                   r_more;

    logic                   mem_we;
    logic [IW-1:0]          mem_wa;

    logic [TARGET_BITS-1:0] e_tgt;
    logic [TIME_BITS-1:0]   e_dl;
    logic [STAMP_BITS-1:0]  e_age;
    logic                   e_v;
    logic                   e_due;
    logic                   e_match;
    logic                   take;
    logic                   ins_ok;
    logic [IW-1:0]          ins_idx;

    assign e_tgt   = r_rd[MW-1 -: TARGET_BITS];
    assign e_dl    = r_rd[STAMP_BITS +: TIME_BITS];
    assign e_age   = r_icount - r_rd[STAMP_BITS-1:0];
    assign e_v     = r_valid[r_cidx];
    assign e_due   = e_v && (e_dl <= r_now);
    assign e_match = e_v && (e_tgt == r_tgt) && (e_dl == r_dl);

    always_comb begin
        take = 1'b0;
        if (r_code == OP_TICK) begin
            take = e_due && (!r_found || (e_dl < r_best_dl) ||
                   ((e_dl == r_best_dl) && (e_age > r_best_age)));
        end else begin
            take = e_match && (!r_found || (e_age > r_best_age));
        end
    end

    always_comb begin
        ins_ok  = r_free_found || r_found;
        ins_idx = r_free;
        if (r_found && (!r_free_found || (r_best < r_free))) begin
            ins_idx = r_best;
        end
        if (r_code == OP_SCHEDULE) begin
            ins_ok  = r_free_found;
            ins_idx = r_free;
        end
    end

    assign mem_we = (r_state == ST_FINISH) && ins_ok && ((r_code == OP_SCHEDULE) ||
                    ((r_code == OP_RESCHEDULE) && !(r_ndl <= r_now)));
    assign mem_wa = ins_idx;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= {r_tgt, ((r_code == OP_SCHEDULE) ? r_dl : r_ndl), r_icount};
        end
        r_rd   <= r_mem[r_idx[IW-1:0]];
        r_cidx <= r_idx[IW-1:0];
    end

    assign o_cmd_pop  = (r_state == ST_IDLE) && !i_cmd_empty;
    assign o_res_push = (r_state == ST_PUSH);
    assign o_kind     = r_kind;
    assign o_target   = r_otgt;
    assign o_deadline = r_odl;
    assign o_last     = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_icount <= '0;
            r_cvalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_cvalid <= (r_state == ST_SCAN) && (r_idx < DEPTH_N);
            case (r_state)
                ST_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_code       <= i_code;
                        r_tgt        <= i_target;
                        r_dl         <= i_deadline;
                        r_ndl        <= i_new_deadline;
                        r_now        <= i_now;
                        r_idx        <= '0;
                        r_found      <= 1'b0;
                        r_free_found <= 1'b0;
                        r_count      <= '0;
                        r_state      <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_idx < DEPTH_N) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_cvalid) begin
                        if (take) begin
                            r_found    <= 1'b1;
                            r_best     <= r_cidx;
                            r_best_dl  <= e_dl;
                            r_best_tgt <= e_tgt;
                            r_best_age <= e_age;
                        end
                        if (e_due) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (!e_v && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free       <= r_cidx;
                        end
                        if ((r_code == OP_CANCEL_ALL) && e_v && (e_tgt == r_tgt)) begin
                            r_valid[r_cidx] <= 1'b0;
                        end
                        if ({1'b0, r_cidx} == LAST_IDX) begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    r_kind  <= KIND_DONE;
                    r_otgt  <= '0;
                    r_odl   <= '0;
                    r_olast <= 1'b1;
                    r_more  <= 1'b0;
                    case (r_code)
                        OP_TICK: begin
                            if (r_found) begin
                                r_valid[r_best] <= 1'b0;
                                r_kind  <= KIND_FIRED;
                                r_otgt  <= r_best_tgt;
                                r_odl   <= r_best_dl;
                                r_olast <= (r_count == (IW + 1)'(1));
                                r_more  <= (r_count != (IW + 1)'(1));
                            end
                        end
                        OP_SCHEDULE: begin
                            if (ins_ok) begin
                                r_valid[ins_idx] <= 1'b1;
                                r_icount <= r_icount + 1'b1;
                            end else begin
                                r_kind <= KIND_FULL;
                            end
                        end
                        OP_CANCEL_ONE: begin
                            if (r_found) begin
                                r_valid[r_best] <= 1'b0;
                            end
                        end
                        OP_RESCHEDULE: begin
                            if (r_ndl <= r_now) begin
                                if (r_found) begin
                                    r_valid[r_best] <= 1'b0;
                                end
                                r_kind <= KIND_FIRED;
                                r_otgt <= r_tgt;
                                r_odl  <= r_ndl;
                            end else if (ins_ok) begin
                                if (r_found && (ins_idx != r_best)) begin
                                    r_valid[r_best] <= 1'b0;
                                end
                                r_valid[ins_idx] <= 1'b1;
                                r_icount <= r_icount + 1'b1;
                            end else begin
                                r_kind <= KIND_FULL;
                            end
                        end
                        default: begin
                        end
                    endcase
                    r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!i_res_full) begin
                        if (r_more) begin
                            r_idx        <= '0;
                            r_found      <= 1'b0;
                            r_free_found <= 1'b0;
                            r_count      <= '0;
                            r_state      <= ST_SCAN;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ src/deadline_timer_queue.sv @@
// Deadline timer queue top level: front command queue, table back end, result queue.
// Depends on dtq_pkg, dtq_fifo, dtq_front and dtq_back.
// Each request takes one pass over the table of DEPTH slots, one slot per cycle from a
// memory; a tick that fires n timers makes n passes. Up to two requests wait in front
// and two results behind.
module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int TARGET_BITS = TARGET_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [OP_BITS-1:0]     i_op,
    input  logic [TARGET_BITS-1:0] i_target,
    input  logic [TIME_BITS-1:0]   i_deadline,
    input  logic [TIME_BITS-1:0]   i_new_deadline,
    input  logic [TIME_BITS-1:0]   i_now,
    output logic                   empty,
    input  logic                   pop,
    output logic [KIND_BITS-1:0]   o_kind,
    output logic [TARGET_BITS-1:0] o_fired_target,
    output logic [TIME_BITS-1:0]   o_fired_deadline,
    output logic                   o_last
);

    localparam int RW = KIND_BITS + TARGET_BITS + TIME_BITS + 1;

    logic                   cmd_empty;
    logic                   cmd_pop;
    logic [OP_BITS-1:0]     cmd_code;
    logic [TARGET_BITS-1:0] cmd_tgt;
    logic [TIME_BITS-1:0]   cmd_dl;
    logic [TIME_BITS-1:0]   cmd_ndl;
    logic [TIME_BITS-1:0]   cmd_now;
    logic                   res_full;
    logic                   res_push;
    logic [KIND_BITS-1:0]   res_kind;
    logic [TARGET_BITS-1:0] res_tgt;
    logic [TIME_BITS-1:0]   res_dl;
    logic                   res_last;
    logic [RW-1:0]          res_out;

    dtq_front #(.TARGET_BITS(TARGET_BITS), .TIME_BITS(TIME_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_op           (i_op),
        .i_target       (i_target),
        .i_deadline     (i_deadline),
        .i_new_deadline (i_new_deadline),
        .i_now          (i_now),
        .i_pop          (cmd_pop),
        .o_empty        (cmd_empty),
        .o_code         (cmd_code),
        .o_target       (cmd_tgt),
        .o_deadline     (cmd_dl),
        .o_new_deadline (cmd_ndl),
        .o_now          (cmd_now)
    );

    dtq_back #(.DEPTH(DEPTH), .TARGET_BITS(TARGET_BITS), .TIME_BITS(TIME_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_empty    (cmd_empty),
        .o_cmd_pop      (cmd_pop),
        .i_code         (cmd_code),
        .i_target       (cmd_tgt),
        .i_deadline     (cmd_dl),
        .i_new_deadline (cmd_ndl),
        .i_now          (cmd_now),
        .i_res_full     (res_full),
        .o_res_push     (res_push),
        .o_kind         (res_kind),
        .o_target       (res_tgt),
        .o_deadline     (res_dl),
        .o_last         (res_last)
    );

    dtq_fifo #(.WIDTH(RW)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({res_kind, res_tgt, res_dl, res_last}),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign {o_kind, o_fired_target, o_fired_deadline, o_last} = res_out;

endmodule
